@@ hdl/ese_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision package
// Widths, register indexes and the control/status types shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ese_pkg;

  localparam int MAX_SEGS   = 64;
  localparam int CNT_W      = 7;
  localparam int NODE_W     = 16;
  localparam int COORD_W    = 32;
  localparam int SIZE_W     = 32;
  localparam int MAG_W      = 33;
  localparam int SUM_W      = 66;
  localparam int RAD_W      = 68;
  localparam int ROOT_W     = 34;
  localparam int REM_W      = 37;
  localparam int DIV_DW     = 41;
  localparam int DIV_VW     = 34;
  localparam int K_W        = 8;
  localparam int IT_W       = 6;
  localparam int SQRT_ITERS = 34;
  localparam int DIV_ITERS  = 41;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       sq_step;
    logic [1:0] axis;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       cnt_div_start;
    logic       cnt_set;
    logic       int_div_start;
    logic       mid_sel;
    logic       div_step;
    logic       store_new;
    logic       store_mid;
    logic       emit_build;
    logic       next_elem;
  } dp_cmd_t;

  typedef struct packed {
    logic size_zero;
    logic quad;
    logic inner;
  } dp_stat_t;

  typedef struct packed {
    logic [NODE_W-1:0]         elem_first;
    logic [NODE_W-1:0]         elem_second;
    logic [NODE_W-1:0]         elem_mid;
    logic                      new_end_valid;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] new_z;
    logic signed [COORD_W-1:0] mid_x;
    logic signed [COORD_W-1:0] mid_y;
    logic signed [COORD_W-1:0] mid_z;
    logic                      last_elem;
    logic                      count_clipped;
  } elem_t;

endpackage

@@ hdl/ese_ifaces.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision channels
// Valid/ready interfaces for the edge input and the element output.
// ----------------------------------------------------------------------------
interface ese_edge_if;
  logic               valid;
  logic               ready;
  logic [15:0]        start_node;
  logic [15:0]        end_node;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source (output valid, start_node, end_node, start_x, start_y, start_z,
                  end_x, end_y, end_z, input ready);
  modport sink (input valid, start_node, end_node, start_x, start_y, start_z,
                end_x, end_y, end_z, output ready);
endinterface

interface ese_elem_if;
  logic               valid;
  logic               ready;
  logic [15:0]        elem_first;
  logic [15:0]        elem_second;
  logic [15:0]        elem_mid;
  logic               new_end_valid;
  logic signed [31:0] new_x;
  logic signed [31:0] new_y;
  logic signed [31:0] new_z;
  logic signed [31:0] mid_x;
  logic signed [31:0] mid_y;
  logic signed [31:0] mid_z;
  logic               last_elem;
  logic               count_clipped;

  modport source (output valid, elem_first, elem_second, elem_mid, new_end_valid,
                  new_x, new_y, new_z, mid_x, mid_y, mid_z, last_elem,
                  count_clipped, input ready);
  modport sink (input valid, elem_first, elem_second, elem_mid, new_end_valid,
                new_x, new_y, new_z, mid_x, mid_y, mid_z, last_elem,
                count_clipped, output ready);
endinterface

@@ hdl/ese_div_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider lane
// Restoring unsigned divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module ese_div_lane (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [ese_pkg::DIV_DW-1:0] dividend,
  input  logic [ese_pkg::DIV_VW-1:0] divisor,
  output logic [ese_pkg::DIV_DW-1:0] quotient
);
  import ese_pkg::*;

  logic [DIV_VW-1:0] rem;
  logic [DIV_VW-1:0] dvs;
  logic [DIV_DW-1:0] quo;
  logic [DIV_VW:0]   trial;
  logic              take;

  assign trial    = {rem, quo[DIV_DW-1]};
  assign take     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (step) begin
      // The remainder stays below the divisor, so it fits back in DIV_VW bits.
      rem <= take ? DIV_VW'(trial - {1'b0, dvs}) : DIV_VW'(trial);
      quo <= {quo[DIV_DW-2:0], take};
    end
  end
endmodule

@@ hdl/ese_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision datapath
// Configuration registers, length by square root, count and node placement.
// ----------------------------------------------------------------------------
module ese_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ese_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [15:0]                   start_node,
  input  logic [15:0]                   end_node,
  input  logic signed [31:0]            start_x,
  input  logic signed [31:0]            start_y,
  input  logic signed [31:0]            start_z,
  input  logic signed [31:0]            end_x,
  input  logic signed [31:0]            end_y,
  input  logic signed [31:0]            end_z,
  input  ese_pkg::dp_cmd_t              cmd,
  output ese_pkg::dp_stat_t             stat,
  output ese_pkg::elem_t                elem
);
  import ese_pkg::*;

  logic [SIZE_W-1:0]         size;
  logic                      quad;
  logic [NODE_W-1:0]         next_node;
  logic [NODE_W-1:0]         prev_node;
  logic [NODE_W-1:0]         end_n;
  logic signed [COORD_W-1:0] pa [3];
  logic [MAG_W-1:0]          mag [3];
  logic                      neg [3];
  logic [SUM_W-1:0]          sum;
  logic [RAD_W-1:0]          rad;
  logic [ROOT_W-1:0]         root;
  logic [REM_W-1:0]          rem;
  logic [CNT_W-1:0]          n;
  logic [CNT_W-1:0]          idx;
  logic                      clipped;
  logic signed [COORD_W-1:0] newc [3];
  logic signed [COORD_W-1:0] midc [3];

  logic signed [COORD_W-1:0] in_a [3];
  logic signed [COORD_W-1:0] in_b [3];
  logic signed [MAG_W-1:0]   diff [3];
  logic [MAG_W-1:0]          sq_op;
  logic [2*MAG_W-1:0]        sq;
  logic [REM_W-1:0]          st;
  logic [REM_W-1:0]          strial;
  logic [K_W-1:0]            k;
  logic [DIV_DW-1:0]         dvd [3];
  logic [DIV_VW-1:0]         dvs;
  logic [DIV_DW-1:0]         quo [3];
  logic                      inner;

  assign in_a[0] = start_x;
  assign in_a[1] = start_y;
  assign in_a[2] = start_z;
  assign in_b[0] = end_x;
  assign in_b[1] = end_y;
  assign in_b[2] = end_z;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = {in_b[j][COORD_W-1], in_b[j]} - {in_a[j][COORD_W-1], in_a[j]};
    end
  end

  always_comb begin
    case (cmd.axis)
      2'd0:    sq_op = mag[0];
      2'd1:    sq_op = mag[1];
      2'd2:    sq_op = mag[2];
      default: sq_op = '0;
    endcase
  end
  assign sq = sq_op * sq_op;

  // Two radicand bits enter the partial remainder on each square-root step.
  assign st     = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign strial = {1'b0, root, 2'b01};

  assign inner = ({1'b0, idx} + 8'd1) < {1'b0, n};
  assign k     = cmd.mid_sel ? {idx, 1'b1} : ({idx, 1'b0} + K_W'(2));

  always_comb begin
    if (cmd.cnt_div_start) begin
      for (int j = 0; j < 3; j++) begin
        dvd[j] = DIV_DW'({1'b0, root} + {3'b000, size});
      end
      dvs = {1'b0, size, 1'b0};
    end else begin
      for (int j = 0; j < 3; j++) begin
        dvd[j] = DIV_DW'(mag[j] * k) + DIV_DW'(n);
      end
      dvs = DIV_VW'({n, 1'b0});
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ese_div_lane u_div (
      .clk      (clk),
      .load     (cmd.cnt_div_start | cmd.int_div_start),
      .step     (cmd.div_step),
      .dividend (dvd[g]),
      .divisor  (dvs),
      .quotient (quo[g])
    );
  end

  assign stat.size_zero = (size == '0);
  assign stat.quad      = quad;
  assign stat.inner     = inner;

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= '0;
      quad      <= 1'b0;
      next_node <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE:  size <= cfg_data;
          CFG_QUAD:  quad <= cfg_data[0];
          CFG_FIRST: next_node <= cfg_data[NODE_W-1:0];
          default:   ;
        endcase
      end
      if (cmd.emit_build) begin
        next_node <= next_node + NODE_W'(inner) + NODE_W'(quad);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      prev_node <= start_node;
      end_n     <= end_node;
      idx       <= '0;
      n         <= CNT_W'(1);
      clipped   <= 1'b0;
      for (int j = 0; j < 3; j++) begin
        pa[j]  <= in_a[j];
        neg[j] <= diff[j][MAG_W-1];
        mag[j] <= diff[j][MAG_W-1] ? MAG_W'(-diff[j]) : MAG_W'(diff[j]);
      end
    end
    if (cmd.sq_step) begin
      sum <= ((cmd.axis == 2'd0) ? '0 : sum) + sq;
    end
    if (cmd.sqrt_start) begin
      rad  <= {sum, 2'b00};
      root <= '0;
      rem  <= '0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (st >= strial) begin
        rem  <= st - strial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= st;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.cnt_set) begin
      if (quo[0] == '0) begin
        n <= CNT_W'(1);
      end else if (quo[0] > DIV_DW'(MAX_SEGS)) begin
        n       <= CNT_W'(MAX_SEGS);
        clipped <= 1'b1;
      end else begin
        n <= quo[0][CNT_W-1:0];
      end
    end
    for (int j = 0; j < 3; j++) begin
      if (cmd.store_new) begin
        newc[j] <= neg[j] ? pa[j] - quo[j][COORD_W-1:0] : pa[j] + quo[j][COORD_W-1:0];
      end
      if (cmd.store_mid) begin
        midc[j] <= neg[j] ? pa[j] - quo[j][COORD_W-1:0] : pa[j] + quo[j][COORD_W-1:0];
      end
    end
    if (cmd.emit_build) begin
      elem.elem_first    <= prev_node;
      elem.elem_second   <= inner ? next_node : end_n;
      elem.elem_mid      <= quad ? (inner ? next_node + NODE_W'(1) : next_node) : '0;
      elem.new_end_valid <= inner;
      elem.new_x         <= inner ? newc[0] : '0;
      elem.new_y         <= inner ? newc[1] : '0;
      elem.new_z         <= inner ? newc[2] : '0;
      elem.mid_x         <= quad ? midc[0] : '0;
      elem.mid_y         <= quad ? midc[1] : '0;
      elem.mid_z         <= quad ? midc[2] : '0;
      elem.last_elem     <= !inner;
      elem.count_clipped <= clipped;
    end
    if (cmd.next_elem) begin
      idx       <= idx + CNT_W'(1);
      prev_node <= elem.elem_second;
    end
  end
endmodule

@@ hdl/ese_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision controller
// Sequences squaring, square root, count division and per-element placement.
// ----------------------------------------------------------------------------
module ese_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ese_pkg::dp_stat_t stat,
  output ese_pkg::dp_cmd_t  cmd
);
  import ese_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_SQI   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_CDL   = 4'd4;
  localparam logic [3:0] S_CDIV  = 4'd5;
  localparam logic [3:0] S_CSET  = 4'd6;
  localparam logic [3:0] S_ELEM  = 4'd7;
  localparam logic [3:0] S_DIVE  = 4'd8;
  localparam logic [3:0] S_STE   = 4'd9;
  localparam logic [3:0] S_DIVM  = 4'd10;
  localparam logic [3:0] S_STM   = 4'd11;
  localparam logic [3:0] S_BUILD = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]      state;
  logic [3:0]      state_next;
  logic [IT_W-1:0] it;
  logic [IT_W-1:0] it_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    it_next    = it + IT_W'(1);
    cmd        = '0;
    case (state)
      S_IDLE: begin
        it_next = '0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.size_zero ? S_ELEM : S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.axis    = it[1:0];
        if (it == IT_W'(2)) begin
          state_next = S_SQI;
        end
      end
      S_SQI: begin
        cmd.sqrt_start = 1'b1;
        it_next        = '0;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (it == IT_W'(SQRT_ITERS - 1)) begin
          state_next = S_CDL;
        end
      end
      S_CDL: begin
        cmd.cnt_div_start = 1'b1;
        it_next           = '0;
        state_next        = S_CDIV;
      end
      S_CDIV: begin
        cmd.div_step = 1'b1;
        if (it == IT_W'(DIV_ITERS - 1)) begin
          state_next = S_CSET;
        end
      end
      S_CSET: begin
        cmd.cnt_set = 1'b1;
        state_next  = S_ELEM;
      end
      S_ELEM: begin
        it_next = '0;
        if (stat.inner) begin
          cmd.int_div_start = 1'b1;
          state_next        = S_DIVE;
        end else if (stat.quad) begin
          cmd.int_div_start = 1'b1;
          cmd.mid_sel       = 1'b1;
          state_next        = S_DIVM;
        end else begin
          state_next = S_BUILD;
        end
      end
      S_DIVE: begin
        cmd.div_step = 1'b1;
        if (it == IT_W'(DIV_ITERS - 1)) begin
          state_next = S_STE;
        end
      end
      S_STE: begin
        cmd.store_new = 1'b1;
        it_next       = '0;
        if (stat.quad) begin
          cmd.int_div_start = 1'b1;
          cmd.mid_sel       = 1'b1;
          state_next        = S_DIVM;
        end else begin
          state_next = S_BUILD;
        end
      end
      S_DIVM: begin
        cmd.div_step = 1'b1;
        if (it == IT_W'(DIV_ITERS - 1)) begin
          state_next = S_STM;
        end
      end
      S_STM: begin
        cmd.store_mid = 1'b1;
        state_next    = S_BUILD;
      end
      S_BUILD: begin
        cmd.emit_build = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.inner) begin
            cmd.next_elem = 1'b1;
            state_next    = S_ELEM;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      it    <= '0;
    end else begin
      state <= state_next;
      it    <= it_next;
    end
  end
endmodule

@@ hdl/edge_subdivision_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision engine
// Splits straight edges into evenly spaced beam elements.
// ----------------------------------------------------------------------------
// One edge is taken at a time. With a nonzero element size the segment count
// takes three squarings on one shared multiplier, 34 steps of a bit-serial
// square root and 41 steps of a restoring divider. Each element but the last
// then takes one divider pass for its interior end node, and each element one
// more for its midpoint node in quadratic mode; the three coordinates run side
// by side in three 41-step divider lanes. The element is then built and handed
// over. The input is ready only when the previous edge has delivered its last
// element.
module edge_subdivision_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ese_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  ese_edge_if.sink                      edge_in,
  ese_elem_if.source                    elem_out
);
  import ese_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  elem_t    elem;

  ese_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edge_in.valid),
    .in_ready  (edge_in.ready),
    .out_valid (elem_out.valid),
    .out_ready (elem_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ese_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .start_node (edge_in.start_node),
    .end_node   (edge_in.end_node),
    .start_x    (edge_in.start_x),
    .start_y    (edge_in.start_y),
    .start_z    (edge_in.start_z),
    .end_x      (edge_in.end_x),
    .end_y      (edge_in.end_y),
    .end_z      (edge_in.end_z),
    .cmd        (cmd),
    .stat       (stat),
    .elem       (elem)
  );

  assign elem_out.elem_first    = elem.elem_first;
  assign elem_out.elem_second   = elem.elem_second;
  assign elem_out.elem_mid      = elem.elem_mid;
  assign elem_out.new_end_valid = elem.new_end_valid;
  assign elem_out.new_x         = elem.new_x;
  assign elem_out.new_y         = elem.new_y;
  assign elem_out.new_z         = elem.new_z;
  assign elem_out.mid_x         = elem.mid_x;
  assign elem_out.mid_y         = elem.mid_y;
  assign elem_out.mid_z         = elem.mid_z;
  assign elem_out.last_elem     = elem.last_elem;
  assign elem_out.count_clipped = elem.count_clipped;
endmodule

@@ tb/sv/ese_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision scoreboard
// Follows register writes and accepted edges, works out the beam elements each
// edge must produce and compares every delivered element field by field.
// ----------------------------------------------------------------------------
module ese_scoreboard (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ese_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  ese_edge_if                           edge_mon,
  ese_elem_if                           elem_mon,
  output int                            fail_count,
  output int                            pending
);
  import ese_pkg::*;

  logic [31:0]       size_q;
  logic              quad_q;
  logic [NODE_W-1:0] node_ctr;
  elem_t             elem_queue[$];

  assign pending = elem_queue.size();

  // Rounds |b - a| * k / (2n) to nearest, ties away from zero, then offsets a.
  function automatic logic signed [31:0] lerp_coord(logic signed [31:0] a,
                                                    logic signed [31:0] b,
                                                    int unsigned k, int unsigned n);
    logic signed [32:0] d;
    logic [32:0]        mag;
    logic [47:0]        q;
    d   = 33'(b) - 33'(a);
    mag = d[32] ? 33'(-d) : 33'(d);
    q   = (48'(mag) * 48'(k) + 48'(n)) / (48'(2 * n));
    return d[32] ? 32'(a - q[31:0]) : 32'(a + q[31:0]);
  endfunction

  function automatic int unsigned segment_total(logic signed [31:0] ax, logic signed [31:0] ay,
                                                logic signed [31:0] az, logic signed [31:0] bx,
                                                logic signed [31:0] by, logic signed [31:0] bz,
                                                output logic clipped);
    logic signed [32:0] d [3];
    logic [71:0] rad, prod;
    logic [35:0] lo, hi, mid;
    logic [39:0] cnt;
    clipped = 1'b0;
    if (size_q == 0) return 1;
    d[0] = 33'(bx) - 33'(ax);
    d[1] = 33'(by) - 33'(ay);
    d[2] = 33'(bz) - 33'(az);
    rad = 0;
    for (int j = 0; j < 3; j++) rad += 72'(d[j] * d[j]);
    rad = rad << 2;
    lo = 0;
    hi = 36'h8_0000_0000;
    while (hi - lo > 1) begin
      mid  = lo + ((hi - lo) >> 1);
      prod = 72'(mid) * 72'(mid);
      if (prod <= rad) lo = mid; else hi = mid;
    end
    cnt = (40'(lo) + 40'(size_q)) / (40'(size_q) << 1);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_SEGS) begin
      cnt     = 40'(MAX_SEGS);
      clipped = 1'b1;
    end
    return int'(cnt);
  endfunction

  task automatic predict_edge();
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic [NODE_W-1:0]  from_node;
    logic               clipped;
    int unsigned        n;
    elem_t              e;
    a[0] = edge_mon.start_x; a[1] = edge_mon.start_y; a[2] = edge_mon.start_z;
    b[0] = edge_mon.end_x;   b[1] = edge_mon.end_y;   b[2] = edge_mon.end_z;
    n = segment_total(a[0], a[1], a[2], b[0], b[1], b[2], clipped);
    from_node = edge_mon.start_node;
    for (int unsigned i = 0; i < n; i++) begin
      e = '0;
      e.elem_first = from_node;
      if (i + 1 < n) begin
        e.elem_second   = node_ctr;
        node_ctr        = node_ctr + 1'b1;
        e.new_end_valid = 1'b1;
        e.new_x = lerp_coord(a[0], b[0], 2 * (i + 1), n);
        e.new_y = lerp_coord(a[1], b[1], 2 * (i + 1), n);
        e.new_z = lerp_coord(a[2], b[2], 2 * (i + 1), n);
      end else begin
        e.elem_second = edge_mon.end_node;
        e.last_elem   = 1'b1;
      end
      if (quad_q) begin
        e.elem_mid = node_ctr;
        node_ctr   = node_ctr + 1'b1;
        e.mid_x = lerp_coord(a[0], b[0], 2 * i + 1, n);
        e.mid_y = lerp_coord(a[1], b[1], 2 * i + 1, n);
        e.mid_z = lerp_coord(a[2], b[2], 2 * i + 1, n);
      end
      e.count_clipped = clipped;
      elem_queue.push_back(e);
      from_node = e.elem_second;
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    elem_t want;
    if (rst) begin
      size_q     <= '0;
      quad_q     <= 1'b0;
      node_ctr   = '0;
      fail_count <= 0;
      elem_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIZE:  size_q <= cfg_data;
          CFG_QUAD:  quad_q <= cfg_data[0];
          CFG_FIRST: node_ctr = cfg_data[15:0];
          default: ;
        endcase
      end
      if (edge_mon.valid && edge_mon.ready) predict_edge();
      if (elem_mon.valid && elem_mon.ready) begin
        if (elem_queue.size() == 0) begin
          fail_count++;
          $display("%0t: element delivered with none expected, got first=%h second=%h",
                   $time, elem_mon.elem_first, elem_mon.elem_second);
        end else begin
          want = elem_queue.pop_front();
          check_field("elem_first", 32'(want.elem_first), 32'(elem_mon.elem_first));
          check_field("elem_second", 32'(want.elem_second), 32'(elem_mon.elem_second));
          check_field("elem_mid", 32'(want.elem_mid), 32'(elem_mon.elem_mid));
          check_field("new_end_valid", 32'(want.new_end_valid),
                      32'(elem_mon.new_end_valid));
          check_field("new_x", want.new_x, elem_mon.new_x);
          check_field("new_y", want.new_y, elem_mon.new_y);
          check_field("new_z", want.new_z, elem_mon.new_z);
          check_field("mid_x", want.mid_x, elem_mon.mid_x);
          check_field("mid_y", want.mid_y, elem_mon.mid_y);
          check_field("mid_z", want.mid_z, elem_mon.mid_z);
          check_field("last_elem", 32'(want.last_elem), 32'(elem_mon.last_elem));
          check_field("count_clipped", 32'(want.count_clipped),
                      32'(elem_mon.count_clipped));
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge subdivision engine testbench
// Drives directed and random edges under several register settings with
// random back-pressure and gaps; the scoreboard checks every element.
// ----------------------------------------------------------------------------
module tb_top;
  import ese_pkg::*;

  localparam int IDLE_LIMIT = 60000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   fail_count;
  int                   pending;
  int                   idle_cycles;
  int                   stall_left;
  bit                   calm;

  ese_edge_if edge_ch ();
  ese_elem_if elem_ch ();

  edge_subdivision_engine_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .edge_in(edge_ch), .elem_out(elem_ch)
  );

  ese_scoreboard scoreboard (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .edge_mon(edge_ch), .elem_mon(elem_ch), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure in random bursts, switched off near the end.
  always @(posedge clk) begin
    if (rst) begin
      elem_ch.ready <= 1'b0;
      stall_left    <= 0;
    end else if (calm) begin
      elem_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      elem_ch.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      elem_ch.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 8);
    end else begin
      elem_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (edge_ch.valid && edge_ch.ready) || (elem_ch.valid && elem_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(logic [31:0] size, logic quad, logic [15:0] first);
    drain();
    write_reg(CFG_SIZE, size);
    write_reg(CFG_QUAD, {31'b0, quad});
    write_reg(CFG_FIRST, {16'b0, first});
    @(posedge clk);
  endtask

  task automatic send_edge(logic [15:0] na, logic [15:0] nb,
                           logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                           logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      edge_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    edge_ch.valid      <= 1'b1;
    edge_ch.start_node <= na;
    edge_ch.end_node   <= nb;
    edge_ch.start_x    <= ax;
    edge_ch.start_y    <= ay;
    edge_ch.start_z    <= az;
    edge_ch.end_x      <= bx;
    edge_ch.end_y      <= by;
    edge_ch.end_z      <= bz;
    do @(posedge clk); while (!edge_ch.ready);
    edge_ch.valid <= 1'b0;
    // The block is busy right after an accept, so this cycle costs nothing.
    @(posedge clk);
  endtask

  // Endpoint offset of up to about three element sizes, kept inside 32 bits.
  function automatic logic [31:0] near_point(logic [31:0] from, logic [31:0] size);
    longint span, delta, dest;
    span  = longint'(size) * 3;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    delta = longint'({$urandom, $urandom}) % (span + 1);
    if (delta < 0) delta = -delta;
    if ($urandom_range(0, 1)) delta = -delta;
    dest = longint'(signed'(from)) + delta;
    if (dest > 64'sh7FFF_FFFF || dest < -64'sh8000_0000)
      dest = longint'(signed'(from)) - delta;
    return dest[31:0];
  endfunction

  task automatic random_phase(int count, logic [31:0] size);
    logic [31:0] ax, ay, az;
    for (int i = 0; i < count; i++) begin
      ax = $urandom; ay = $urandom; az = $urandom;
      if ($urandom_range(0, 6) == 0) begin
        send_edge(16'($urandom), 16'($urandom), ax, ay, az, $urandom, $urandom, $urandom);
      end else begin
        send_edge(16'($urandom), 16'($urandom), ax, ay, az, near_point(ax, size),
                  near_point(ay, size), near_point(az, size));
      end
    end
  endtask

  initial begin
    logic [31:0] size;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    calm               = 1'b0;
    edge_ch.valid      <= 1'b0;
    edge_ch.start_node <= '0;
    edge_ch.end_node   <= '0;
    edge_ch.start_x    <= '0;
    edge_ch.start_y    <= '0;
    edge_ch.start_z    <= '0;
    edge_ch.end_x      <= '0;
    edge_ch.end_y      <= '0;
    edge_ch.end_z      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero element size after reset: a single element for any edge.
    send_edge(16'h0000, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_edge(16'h1234, 16'h4321, 32'h0001_0000, 32'h0, 32'h0, 32'h0005_0000, 32'h0, 32'h0);

    // Unit size, quadratic, node counter close to wrapping.
    setup(32'h0001_0000, 1'b1, 16'hFFFD);
    send_edge(16'd1, 16'd2, 32'h0003_0000, 32'hFFFF_0000, 32'h0, 32'h0003_0000,
              32'hFFFF_0000, 32'h0);
    send_edge(16'd2, 16'd3, 32'h0, 32'h0, 32'h0, 32'h0000_4000, 32'h0, 32'h0);
    send_edge(16'd3, 16'd4, 32'h0, 32'h0, 32'h0, 32'h0005_0000, 32'h0003_0000, 32'h0);
    send_edge(16'd4, 16'd5, 32'h0, 32'h0, 32'h0, 32'hFFFC_8000, 32'h0, 32'h0);
    send_edge(16'd5, 16'd6, 32'h0, 32'h0, 32'h0, 32'h0064_0000, 32'h0, 32'h0);

    // Largest size in linear mode.
    setup(32'hFFFF_FFFF, 1'b0, 16'h0000);
    send_edge(16'hFFFF, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_edge(16'h00FF, 16'hFF00, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);

    setup(32'h0000_0001, 1'b0, 16'hFFFF);
    random_phase(6, 32'h0000_0001);
    setup(32'hFFFF_FFFF, 1'b1, 16'($urandom));
    random_phase(20, 32'hFFFF_FFFF);
    setup(32'h0000_0000, 1'b1, 16'($urandom));
    random_phase(10, 32'h0001_0000);
    for (int p = 0; p < 4; p++) begin
      size = $urandom_range(1, 8) << $urandom_range(0, 28);
      setup(size, 1'($urandom_range(0, 1)), 16'($urandom));
      if (p == 3) calm = 1'b1;
      random_phase(22, size);
    end

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/ese_pkg.sv
hdl/ese_ifaces.sv
hdl/ese_div_lane.sv
hdl/ese_dp.sv
hdl/ese_ctrl.sv
hdl/edge_subdivision_engine_unit.sv
tb/sv/ese_scoreboard.sv
tb/sv/tb_top.sv
